### rtl/core/ttne_pkg.sv
// Shared types, cell kind codes and constant tables of the truth table network evaluator.
package ttne_pkg;

  // Default sizing
  localparam int MaxCells  = 1024;
  localparam int MaxVars   = 6;
  localparam int MaxFanin  = 15;
  localparam int TableW    = 64;
  localparam int PosW      = 10;
  localparam int KindW     = 4;
  localparam int VarCountW = 3;

  // Cell kinds; codes 9 to 15 mean nothing and end a cell with a zero table
  typedef enum logic [KindW-1:0] {
    KIND_IN   = 4'd0,
    KIND_OUT  = 4'd1,
    KIND_ZERO = 4'd2,
    KIND_ONE  = 4'd3,
    KIND_BUF  = 4'd4,
    KIND_AND  = 4'd5,
    KIND_OR   = 4'd6,
    KIND_XOR  = 4'd7,
    KIND_MAJ  = 4'd8
  } kind_e;

  // One fan-in link request
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  source_index;
    logic             invert;
    logic             last_link;
    logic             new_network;
  } in_req_t;

  // One output cell result
  typedef struct packed {
    logic [TableW-1:0] table_bits;
    logic [PosW-1:0]   output_number;
  } out_req_t;

  // Projection pattern of input variable idx
  function automatic logic [TableW-1:0] var_pattern(input logic [2:0] idx);
    logic [TableW-1:0] pat;
    unique case (idx)
      3'd0:    pat = 64'hAAAA_AAAA_AAAA_AAAA;
      3'd1:    pat = 64'hCCCC_CCCC_CCCC_CCCC;
      3'd2:    pat = 64'hF0F0_F0F0_F0F0_F0F0;
      3'd3:    pat = 64'hFF00_FF00_FF00_FF00;
      3'd4:    pat = 64'hFFFF_0000_FFFF_0000;
      3'd5:    pat = 64'hFFFF_FFFF_0000_0000;
      default: pat = '0;
    endcase
    return pat;
  endfunction

  // Valid table bits for v variables: 2^v low bits
  function automatic logic [TableW-1:0] table_mask(input logic [VarCountW-1:0] v);
    logic [TableW-1:0] m;
    unique case (v)
      3'd0:    m = 64'h0000_0000_0000_0001;
      3'd1:    m = 64'h0000_0000_0000_0003;
      3'd2:    m = 64'h0000_0000_0000_000F;
      3'd3:    m = 64'h0000_0000_0000_00FF;
      3'd4:    m = 64'h0000_0000_0000_FFFF;
      3'd5:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/ttne_table_mem.sv
// Cell table memory: one write port, one read port, registered read data.
module ttne_table_mem #(
  parameter int DEPTH = ttne_pkg::MaxCells,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [ttne_pkg::TableW-1:0]    wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [ttne_pkg::TableW-1:0]    rdata_o
);

  logic [ttne_pkg::TableW-1:0] mem_q [DEPTH];
  logic [ttne_pkg::TableW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/truth_table_network_evaluator_top.sv
// Top level of the truth table network evaluator: link pipeline, cell state and output register.
//
// Takes one fan-in link request per clock. Each request passes two steps inside: the first
// reads the source table from the cell table memory, the second folds it into the current
// cell and, on the last link, writes the finished table back at the cell position. A table
// written in one cycle and read by the very next link is forwarded around the memory, so
// back-to-back dependent links run at full rate. An output cell result is written into the
// output register when its last link folds into the cell, and it waits there; the
// input stalls only while that register is full and stalled and the link in flight
// finishes another output cell. Tables are stored with no reset: a link must read only
// positions already written.
module truth_table_network_evaluator_top #(
  parameter int MAX_CELLS = ttne_pkg::MaxCells,
  parameter int MAX_VARS  = ttne_pkg::MaxVars,
  parameter int MAX_FANIN = ttne_pkg::MaxFanin
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ttne_pkg::in_req_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ttne_pkg::out_req_t                out_req_o,
  input  logic                              cfg_we_i,
  input  logic [ttne_pkg::VarCountW-1:0]    cfg_wdata_i
);

  localparam int CellAw = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CntW   = $clog2(MAX_FANIN + 1);
  localparam int TW     = ttne_pkg::TableW;
  localparam int PW     = ttne_pkg::PosW;

  // Configuration
  logic [ttne_pkg::VarCountW-1:0] var_cnt_q;
  logic [ttne_pkg::VarCountW-1:0] eff_vars;
  logic [TW-1:0]                  mask;

  // Link stage
  logic              in_accept;
  logic              s1_v_q;
  ttne_pkg::in_req_t s1_req_q;
  logic              s1_src_ok_q;
  logic              s1_adv;
  logic              s1_fire;
  logic              fwd_q;
  logic [TW-1:0]     fwd_data_q;

  // Cell state
  logic [TW-1:0]     acc_q;
  logic [CntW-1:0]   cnt_q [TW];
  logic [CntW-1:0]   links_q;
  logic [PW-1:0]     pos_q;
  logic [PW-1:0]     outs_q;

  // Output register
  logic               out_v_q;
  ttne_pkg::out_req_t out_req_q;

  // Stage combinational values
  logic              restart;
  ttne_pkg::kind_e   kind;
  logic [TW-1:0]     acc_cur;
  logic [CntW-1:0]   cnt_cur [TW];
  logic [CntW-1:0]   links_cur;
  logic [PW-1:0]     pos_cur;
  logic [PW-1:0]     outs_cur;
  logic [TW-1:0]     rd_data;
  logic [TW-1:0]     link_tbl;
  logic              first;
  logic [TW-1:0]     acc_nxt;
  logic [CntW-1:0]   cnt_nxt [TW];
  logic [CntW-1:0]   links_nxt;
  logic [CntW-1:0]   thr;
  logic [TW-1:0]     maj_tbl;
  logic [TW-1:0]     res;
  logic              emit;
  logic              pos_ok;
  logic [31:0]       pos_ext;
  logic [31:0]       src_ext;

  // Memory ports
  logic              mem_we;
  logic [CellAw-1:0] mem_waddr;
  logic [CellAw-1:0] mem_raddr;
  logic              fwd_hit;
  logic [TW-1:0]     s1_ram_data;

  // Effective variable count and table mask
  assign eff_vars = (32'(var_cnt_q) > MAX_VARS) ? ttne_pkg::VarCountW'(MAX_VARS) : var_cnt_q;
  assign mask     = ttne_pkg::table_mask(eff_vars);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_cnt_q <= 3'd6;
    end else if (cfg_we_i) begin
      var_cnt_q <= cfg_wdata_i;
    end
  end

  // Handshake
  assign emit       = s1_req_q.last_link && (kind == ttne_pkg::KIND_OUT);
  assign s1_adv     = !(emit && out_v_q && out_stall_i);
  assign s1_fire    = s1_v_q && s1_adv;
  assign in_stall_o = s1_v_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Read address and range check of the incoming link
  assign src_ext   = 32'(in_req_i.source_index);
  assign mem_raddr = src_ext[CellAw-1:0];

  // Link stage restart view of the cell state
  assign restart   = s1_req_q.new_network;
  assign kind      = ttne_pkg::kind_e'(s1_req_q.kind);
  assign acc_cur   = restart ? '0 : acc_q;
  assign links_cur = restart ? '0 : links_q;
  assign pos_cur   = restart ? '0 : pos_q;
  assign outs_cur  = restart ? '0 : outs_q;

  // Linked table: forwarded or from memory, range checked, inverted, masked
  assign rd_data  = fwd_q ? fwd_data_q : s1_ram_data;
  always_comb begin
    link_tbl = s1_src_ok_q ? rd_data : '0;
    if (s1_req_q.invert) begin
      link_tbl = ~link_tbl;
    end
    link_tbl = link_tbl & mask;
  end

  // Fold the link into the accumulated table
  assign first = (links_cur == '0);
  always_comb begin
    acc_nxt = acc_cur;
    unique case (kind)
      ttne_pkg::KIND_OUT,
      ttne_pkg::KIND_BUF: if (first) acc_nxt = link_tbl;
      ttne_pkg::KIND_AND: acc_nxt = first ? link_tbl : (acc_cur & link_tbl);
      ttne_pkg::KIND_OR:  acc_nxt = first ? link_tbl : (acc_cur | link_tbl);
      ttne_pkg::KIND_XOR: acc_nxt = first ? link_tbl : (acc_cur ^ link_tbl);
      default:            acc_nxt = acc_cur;
    endcase
  end

  // Per-bit majority counters, saturating
  assign links_nxt = (links_cur < CntW'(MAX_FANIN)) ? links_cur + 1'b1 : links_cur;
  assign thr       = links_nxt >> 1;
  always_comb begin
    for (int k = 0; k < TW; k++) begin
      cnt_cur[k] = restart ? '0 : cnt_q[k];
      cnt_nxt[k] = (link_tbl[k] && (cnt_cur[k] < CntW'(MAX_FANIN))) ?
                   cnt_cur[k] + 1'b1 : cnt_cur[k];
      maj_tbl[k] = (cnt_nxt[k] > thr);
    end
  end

  // Cell result on its last link
  always_comb begin
    unique case (kind)
      ttne_pkg::KIND_IN:  res = ({7'd0, eff_vars} > pos_cur) ?
                                ttne_pkg::var_pattern(pos_cur[2:0]) : '0;
      ttne_pkg::KIND_OUT,
      ttne_pkg::KIND_BUF,
      ttne_pkg::KIND_AND,
      ttne_pkg::KIND_OR,
      ttne_pkg::KIND_XOR: res = acc_nxt;
      ttne_pkg::KIND_ONE: res = '1;
      ttne_pkg::KIND_MAJ: res = maj_tbl;
      default:            res = '0;
    endcase
    res = res & mask;
  end

  // Write back the finished table; forward it to a link read in the same cycle
  assign pos_ext   = 32'(pos_cur);
  assign pos_ok    = (pos_ext < MAX_CELLS);
  assign mem_waddr = pos_ext[CellAw-1:0];
  assign mem_we    = s1_fire && s1_req_q.last_link && pos_ok;
  assign fwd_hit   = in_accept && mem_we && (mem_waddr == mem_raddr);

  ttne_table_mem #(
    .DEPTH (MAX_CELLS),
    .AW    (CellAw)
  ) u_table_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (res),
    .re_i    (in_accept),
    .raddr_i (mem_raddr),
    .rdata_o (s1_ram_data)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_data_q <= res;
    end
  end

  // Link stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      fwd_q       <= 1'b0;
      s1_req_q    <= '0;
      s1_src_ok_q <= 1'b0;
    end else if (in_accept) begin
      s1_v_q      <= 1'b1;
      fwd_q       <= fwd_hit;
      s1_req_q    <= in_req_i;
      s1_src_ok_q <= (src_ext < MAX_CELLS);
    end else if (s1_fire) begin
      s1_v_q      <= 1'b0;
    end
  end

  // Cell state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      links_q <= '0;
      pos_q   <= '0;
      outs_q  <= '0;
      for (int k = 0; k < TW; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_req_q.last_link) begin
        acc_q   <= '0;
        links_q <= '0;
        pos_q   <= pos_cur + 1'b1;
        outs_q  <= (kind == ttne_pkg::KIND_OUT) ? outs_cur + 1'b1 : outs_cur;
        for (int k = 0; k < TW; k++) begin
          cnt_q[k] <= '0;
        end
      end else begin
        acc_q   <= acc_nxt;
        links_q <= links_nxt;
        pos_q   <= pos_cur;
        outs_q  <= outs_cur;
        for (int k = 0; k < TW; k++) begin
          cnt_q[k] <= cnt_nxt[k];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_v_q <= 1'b1;
    end else if (out_v_q && !out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_req_q.table_bits    <= res;
      out_req_q.output_number <= outs_cur;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_req_q;

  // Checks
  a_stall_only_on_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_v_q && out_stall_i && s1_v_q))
    else $error("input stalled while output register could take the result");

  a_fwd_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_accept) |-> (fwd_q == $past(fwd_hit)))
    else $error("forward flag does not match the write seen at the link read");

  a_links_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    links_q <= CntW'(MAX_FANIN))
    else $error("link count beyond fan-in limit");

  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && emit) |=> out_v_q)
    else $error("output cell result lost");

endmodule
